@@ hdl/jts_pkg.sv @@
package jts_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int FIELD_W  = 16;
	localparam int SLOT_W   = 4;
	localparam int NOW_W    = 32;
	localparam int POLICY_W = 2;

	// Command codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	// Scheduling policies held in the policy register.
	localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
	localparam logic [POLICY_W-1:0] POL_SPN  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_SRT  = 2'd2;
	localparam logic [POLICY_W-1:0] POL_HRRN = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] length;
	} cmd_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              idle;
		logic              finished;
		logic [NOW_W-1:0]  now;
	} res_item_t;

endpackage

@@ hdl/jts_ifs.sv @@
interface jts_cmd_if;
	logic                  valid;
	logic                  ready;
	jts_pkg::cmd_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface jts_res_if;
	logic                  valid;
	logic                  ready;
	jts_pkg::res_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/jts_ram.sv @@
module jts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/job_table_tick_scheduler_core.sv @@
// Clear and load beats stay in idle; the next command beat is taken in the cycle after.
// A tick beat runs one scan pass and one read-modify-write pass over the job RAM. The response
// ratio policy adds a compare step for each eligible entry after the first in the scan.
// A tick that finds nothing to run skips the write pass. A running non-preemptive job that is
// still eligible skips the scan.
// The tick result sits in an output register, so a stalled consumer only blocks the next tick.
// Reset (arst_n low) empties the table, zeroes time and selects first come first served.
module job_table_tick_scheduler_core #(
	parameter int MAX_JOBS  = jts_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = jts_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [jts_pkg::POLICY_W-1:0]  cfg_wdata,
	jts_cmd_if.sink                       cmd,
	jts_res_if.source                     res
);

	import jts_pkg::*;

	localparam int TB    = TIME_BITS;
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int ENT_W = 4 * TB;
	// Width of one side of the cross-multiplied ratio compare: (waited + length) * length.
	localparam int PW    = 2 * TB + 1;

	// Sequencer states.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] ST_RUNCHK = 4'd1;
	localparam logic [ST_W-1:0] ST_SRD    = 4'd2;
	localparam logic [ST_W-1:0] ST_SCMP   = 4'd3;
	localparam logic [ST_W-1:0] ST_SHR    = 4'd4;
	localparam logic [ST_W-1:0] ST_URD    = 4'd5;
	localparam logic [ST_W-1:0] ST_UWR    = 4'd6;
	localparam logic [ST_W-1:0] ST_DONE   = 4'd7;

	logic [ST_W-1:0]      state_q;
	logic [CNT_W-1:0]     job_cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [NOW_W-1:0]     clock_q;
	logic [IDX_W-1:0]     run_slot_q;
	logic                 run_valid_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 found_q;
	logic                 done_q;
	logic [POLICY_W-1:0]  policy_q;
	logic                 out_valid_q;
	res_item_t            out_data_q;

	// The candidate that currently wins the scan.
	logic [TB-1:0]        best_arr_q;
	logic [TB-1:0]        best_len_q;
	logic [TB-1:0]        best_left_q;
	logic [TB-1:0]        best_wait_q;
	logic [PW-1:0]        prod_a_q;
	logic [PW-1:0]        prod_b_q;

	// Job RAM ports. One entry packs arrival, length, time left and time waited.
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENT_W-1:0]     rd_data;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENT_W-1:0]     wr_data;

	logic [TB-1:0]        q_arr;
	logic [TB-1:0]        q_len;
	logic [TB-1:0]        q_left;
	logic [TB-1:0]        q_wait;
	logic [TB-1:0]        left_dec;
	logic [TB-1:0]        wait_next;
	logic [TB+1-1:0]      q_sum;
	logic [TB+1-1:0]      best_sum;
	logic                 q_elig;
	logic                 better_simple;
	logic                 scan_end;
	logic                 run_in_table;
	logic                 is_pick;
	logic                 table_full;
	logic                 cmd_fire;
	logic                 out_load;

	jts_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign q_arr  = rd_data[3*TB +: TB];
	assign q_len  = rd_data[2*TB +: TB];
	assign q_left = rd_data[TB +: TB];
	assign q_wait = rd_data[0 +: TB];

	// A job may run once it has arrived and still needs time. Zero length jobs never qualify.
	assign q_elig = (q_left != '0) && (NOW_W'(q_arr) <= clock_q);

	assign scan_end     = (idx_q == job_cnt_q);
	assign run_in_table = (CNT_W'(run_slot_q) < job_cnt_q);
	assign is_pick      = (idx_q[IDX_W-1:0] == pick_q);
	assign table_full   = (job_cnt_q == CNT_W'(MAX_JOBS));
	assign left_dec     = q_left - TB'(1);

	// Waiting time saturates at the all-ones value of the time field.
	assign wait_next = (!is_pick && q_elig && (q_wait != '1)) ? q_wait + TB'(1) : q_wait;

	assign q_sum    = (TB+1)'(q_wait) + (TB+1)'(q_len);
	assign best_sum = (TB+1)'(best_wait_q) + (TB+1)'(best_len_q);

	// Strict preference of the entry on the read port over the current best. Ties keep the
	// earlier entry, which is the lower index because the scan runs upward.
	always_comb begin
		case (policy_q)
			POL_FCFS: better_simple = (q_arr < best_arr_q);
			POL_SPN:  better_simple = (q_len < best_len_q);
			POL_SRT:  better_simple = (q_left < best_left_q);
			default:  better_simple = 1'b0;
		endcase
	end

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	// Read port: the running job's entry as a tick starts, then one entry per pass step.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				rd_en   = cmd_fire && (cmd.data.mode == MODE_TICK);
				rd_addr = run_slot_q;
			end
			ST_SRD, ST_URD: begin
				rd_en = !scan_end;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Write port: a load appends at the fill count; the update pass writes back updated entries.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = {q_arr, q_len, is_pick ? left_dec : q_left, wait_next};
		case (state_q)
			ST_IDLE: begin
				wr_en   = cmd_fire && (cmd.data.mode == MODE_LOAD) && !table_full;
				wr_addr = job_cnt_q[IDX_W-1:0];
				wr_data = {TB'(cmd.data.arrival), TB'(cmd.data.length),
				           TB'(cmd.data.length), TB'(0)};
			end
			ST_UWR: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_cnt_q   <= '0;
			idx_q       <= '0;
			clock_q     <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			pick_q      <= '0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			policy_q    <= POL_FCFS;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.data.mode)
							MODE_CLEAR: begin
								job_cnt_q   <= '0;
								clock_q     <= '0;
								run_slot_q  <= '0;
								run_valid_q <= 1'b0;
							end
							MODE_LOAD: begin
								if (!table_full) begin
									job_cnt_q <= job_cnt_q + CNT_W'(1);
								end
							end
							MODE_TICK: begin
								found_q <= 1'b0;
								done_q  <= 1'b0;
								idx_q   <= '0;
								pick_q  <= '0;
								// A job chosen under a non-preemptive policy keeps the CPU.
								if ((policy_q != POL_SRT) && run_valid_q) begin
									state_q <= ST_RUNCHK;
								end else begin
									state_q <= ST_SRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUNCHK: begin
					if (run_in_table && q_elig) begin
						found_q <= 1'b1;
						pick_q  <= run_slot_q;
						state_q <= ST_URD;
					end else begin
						state_q <= ST_SRD;
					end
				end
				ST_SRD: begin
					if (scan_end) begin
						idx_q   <= '0;
						state_q <= found_q ? ST_URD : ST_DONE;
					end else begin
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					if (q_elig && found_q && (policy_q == POL_HRRN)) begin
						state_q <= ST_SHR;
					end else begin
						if (q_elig && (!found_q || better_simple)) begin
							found_q <= 1'b1;
							pick_q  <= idx_q[IDX_W-1:0];
						end
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= ST_SRD;
					end
				end
				ST_SHR: begin
					if (prod_a_q > prod_b_q) begin
						pick_q <= idx_q[IDX_W-1:0];
					end
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= ST_SRD;
				end
				ST_URD: begin
					state_q <= scan_end ? ST_DONE : ST_UWR;
				end
				ST_UWR: begin
					if (is_pick) begin
						done_q <= (left_dec == '0);
					end
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= ST_URD;
				end
				ST_DONE: begin
					if (out_load) begin
						clock_q     <= clock_q + NOW_W'(1);
						run_slot_q  <= found_q ? pick_q : '0;
						run_valid_q <= found_q && !done_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the scan's best candidate, the ratio products and the result beat.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCMP) begin
			// Response ratio compare by cross multiplication, registered before the compare.
			prod_a_q <= PW'(q_sum) * PW'(best_len_q);
			prod_b_q <= PW'(best_sum) * PW'(q_len);
			if (q_elig && (!found_q || better_simple)) begin
				best_arr_q  <= q_arr;
				best_len_q  <= q_len;
				best_left_q <= q_left;
				best_wait_q <= q_wait;
			end
		end
		if ((state_q == ST_SHR) && (prod_a_q > prod_b_q)) begin
			best_arr_q  <= q_arr;
			best_len_q  <= q_len;
			best_left_q <= q_left;
			best_wait_q <= q_wait;
		end
		if (out_load) begin
			out_data_q.slot     <= found_q ? SLOT_W'(pick_q) : '0;
			out_data_q.idle     <= !found_q;
			out_data_q.finished <= found_q && done_q;
			out_data_q.now      <= clock_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_IDLE) || (state_q == ST_UWR)))
		else $error("job RAM written outside a load or the update pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_cnt_q <= CNT_W'(MAX_JOBS))
		else $error("job count beyond table depth");

	a_running_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> run_in_table)
		else $error("running job outside the loaded part of the table");

	a_done_needs_pick: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && done_q) |-> found_q)
		else $error("completion flagged without a chosen job");

	a_ratio_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHR) |-> ((policy_q == POL_HRRN) && found_q))
		else $error("ratio compare step entered without a candidate");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("result beat not presented after a tick");

endmodule
